// ===== rtl/psmd_pkg.sv =====
// Shared types and constants for the potentiometer smoothing and motion detect block.
`default_nettype none
package psmd_pkg;

  localparam int KNOB_W   = 5;
  localparam int SAMPLE_W = 10;
  localparam int VAL_W    = 14;
  localparam int QCNT_W   = 3;
  localparam int E_W      = 16;
  localparam int Y_W      = 21;
  localparam int Q_W      = 7;

  localparam logic [E_W-1:0]    MAP_IN_LO   = 16'd44;
  localparam logic [E_W-1:0]    MAP_SPAN    = 16'd16294;
  localparam logic [VAL_W-1:0]  MAP_OUT_HI  = 14'd16383;
  localparam logic [Y_W-1:0]    SCALE_EXTRA = 21'd89;
  localparam logic [QCNT_W-1:0] QUIET_LIMIT = 3'd3;

  localparam logic REG_START = 1'b0;
  localparam logic REG_STOP  = 1'b1;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_COMMIT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic                oor;
    logic [KNOB_W-1:0]   knob;
    logic [SAMPLE_W-1:0] sample;
    logic                force_motion;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0]  committed;
    logic [VAL_W-1:0]  current;
    logic              moving;
    logic [QCNT_W-1:0] quiet;
  } kstate_t;

  typedef struct packed {
    logic [VAL_W-1:0] start_thr;
    logic [VAL_W-1:0] stop_thr;
  } thr_t;

  typedef struct packed {
    logic              moving;
    logic [VAL_W-1:0]  value;
    logic [KNOB_W-1:0] knob;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/psmd_cfg.sv =====
// Threshold register file behind the APB-style configuration port.
`default_nettype none
module psmd_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready,
  output psmd_pkg::thr_t         thr
);

  logic [psmd_pkg::VAL_W-1:0] start_r;
  logic [psmd_pkg::VAL_W-1:0] stop_r;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 14'd64;
      stop_r  <= 14'd32;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        psmd_pkg::REG_START: start_r <= cfg_pwdata[psmd_pkg::VAL_W-1:0];
        psmd_pkg::REG_STOP:  stop_r  <= cfg_pwdata[psmd_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      psmd_pkg::REG_START: cfg_prdata = {18'd0, start_r};
      psmd_pkg::REG_STOP:  cfg_prdata = {18'd0, stop_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  assign thr.start_thr = start_r;
  assign thr.stop_thr  = stop_r;

endmodule
`default_nettype wire

// ===== rtl/psmd_front.sv =====
// Front end: accepts input transfers, classifies them and queues them for the back end.
`default_nettype none
module psmd_front #(
  parameter int NUM_KNOBS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [0:0]      in_tuser,
  input  wire logic [15:0]     in_tdata,
  output logic                 item_valid,
  output psmd_pkg::item_t      item,
  input  wire logic            item_pop
);

  psmd_pkg::item_t q_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic            push;
  psmd_pkg::item_t in_item;

  always_comb begin
    in_item.cmd          = psmd_pkg::cmd_t'(in_tuser[0]);
    in_item.knob         = in_tdata[4:0];
    in_item.sample       = in_tdata[14:5];
    in_item.force_motion = in_tdata[15];
    in_item.oor          = (32'(in_tdata[4:0]) >= NUM_KNOBS);
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid & in_tready;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !item_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && item_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (item_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psmd_back.sv =====
// Back end: per-knob state memory, smoothing and rescale pipeline, motion logic, result queue.
`default_nettype none
module psmd_back #(
  parameter int NUM_KNOBS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  input  psmd_pkg::item_t      item,
  output logic                 item_pop,
  input  psmd_pkg::thr_t       thr,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [23:0]          out_tdata
);

  localparam int AW = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;

  // knob state store and per-entry valid bits
  psmd_pkg::kstate_t mem_r [NUM_KNOBS];
  logic [NUM_KNOBS-1:0] kvalid_r;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;
  psmd_pkg::kstate_t    rd_data_r;
  logic                 rd_vld_r;

  // pipeline
  logic                 s1_v_r;
  psmd_pkg::item_t      s1_item_r;
  logic                 s2_v_r;
  psmd_pkg::item_t      s2_item_r;
  psmd_pkg::kstate_t    s2_state_r;
  logic                 s2_zero_r;
  logic                 s2_sat_r;
  logic [psmd_pkg::VAL_W-1:0] s2_x_r;
  logic [psmd_pkg::Y_W-1:0]   s2_y_r;

  // last write, for forwarding
  logic                 w_v_r;
  logic [psmd_pkg::KNOB_W-1:0] w_knob_r;
  psmd_pkg::kstate_t    w_state_r;

  // result queue
  psmd_pkg::result_t    oq_r [4];
  logic [1:0]           oq_wr_r;
  logic [1:0]           oq_rd_r;
  logic [2:0]           oq_cnt_r;
  logic [2:0]           oq_cnt_nxt;
  logic [2:0]           in_flight;
  logic                 oq_pop;

  // S1 logic
  psmd_pkg::kstate_t    s1_state;
  logic [12:0]          p;
  logic [12:0]          p_red;
  logic [psmd_pkg::E_W-1:0] e;
  logic [psmd_pkg::E_W-1:0] x_full;
  logic                 s1_zero;
  logic                 s1_sat;
  logic [psmd_pkg::Y_W-1:0] s1_y;

  // S2 logic
  psmd_pkg::kstate_t    s2_state;
  psmd_pkg::kstate_t    st_nxt;
  logic [psmd_pkg::Q_W-1:0]   q0;
  logic [psmd_pkg::Y_W-1:0]   prod;
  logic [psmd_pkg::VAL_W-1:0] q;
  logic [psmd_pkg::VAL_W-1:0] value;
  logic [psmd_pkg::VAL_W-1:0] diff;
  logic [psmd_pkg::QCNT_W-1:0] q_inc;
  psmd_pkg::result_t    res;

  assign in_flight = oq_cnt_r + {2'd0, s1_v_r} + {2'd0, s2_v_r};
  assign item_pop  = item_valid && (in_flight < 3'd4);
  assign rd_addr   = AW'(item.knob);

  always_ff @(posedge clk) begin
    if (item_pop) begin
      rd_data_r <= mem_r[rd_addr];
      rd_vld_r  <= kvalid_r[rd_addr];
      s1_item_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kvalid_r <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      w_v_r    <= 1'b0;
    end else begin
      s1_v_r <= item_pop;
      s2_v_r <= s1_v_r;
      w_v_r  <= wr_en;
      if (wr_en) begin
        kvalid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // S1: merge forwarded state, smooth and start the rescale
  always_comb begin
    s1_state = rd_vld_r ? rd_data_r : '0;
    if (w_v_r && (w_knob_r == s1_item_r.knob)) begin
      s1_state = w_state_r;
    end
    if (s2_v_r && !s2_item_r.oor && (s2_item_r.cmd == psmd_pkg::CMD_COMMIT) &&
        (s2_item_r.knob == s1_item_r.knob)) begin
      s1_state.committed = s2_state.current;
    end
    p       = s1_state.committed[13:1];
    p_red   = p - {3'd0, p[12:3]};
    e       = {({2'd0, p_red} + {5'd0, s1_item_r.sample}), 1'b0};
    s1_zero = (e <= psmd_pkg::MAP_IN_LO);
    x_full  = e - psmd_pkg::MAP_IN_LO;
    s1_sat  = (x_full >= psmd_pkg::MAP_SPAN);
    s1_y    = psmd_pkg::Y_W'(x_full[psmd_pkg::VAL_W-1:0]) * psmd_pkg::SCALE_EXTRA;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_item_r  <= s1_item_r;
      s2_state_r <= s1_state;
      s2_zero_r  <= s1_zero;
      s2_sat_r   <= s1_sat;
      s2_x_r     <= x_full[psmd_pkg::VAL_W-1:0];
      s2_y_r     <= s1_y;
    end
  end

  // S2: finish x*16383/16294 as x + x*89/16294, then motion logic
  always_comb begin
    s2_state = s2_state_r;
    if (w_v_r && (w_knob_r == s2_item_r.knob)) begin
      s2_state = w_state_r;
    end
    q0    = s2_y_r[psmd_pkg::Y_W-1:14];
    prod  = psmd_pkg::Y_W'({7'd0, q0} + 14'd1) * psmd_pkg::Y_W'(psmd_pkg::MAP_SPAN);
    q     = {7'd0, q0} + ((s2_y_r >= prod) ? 14'd1 : 14'd0);
    priority if (s2_zero_r) begin
      value = '0;
    end else if (s2_sat_r) begin
      value = psmd_pkg::MAP_OUT_HI;
    end else begin
      value = s2_x_r + q;
    end
    diff  = (value >= s2_state.committed) ? (value - s2_state.committed)
                                          : (s2_state.committed - value);
    q_inc = s2_state.quiet + 3'd1;

    st_nxt = s2_state;
    unique case (s2_item_r.cmd)
      psmd_pkg::CMD_COMMIT: st_nxt.committed = s2_state.current;
      psmd_pkg::CMD_SAMPLE: begin
        st_nxt.current = value;
        if (!s2_state.moving) begin
          if ((diff > thr.start_thr) || s2_item_r.force_motion) begin
            st_nxt.moving = 1'b1;
          end
        end else if (diff < thr.stop_thr) begin
          if (q_inc > psmd_pkg::QUIET_LIMIT) begin
            st_nxt.moving = 1'b0;
            st_nxt.quiet  = '0;
          end else begin
            st_nxt.quiet = q_inc;
          end
        end else begin
          st_nxt.quiet = '0;
        end
      end
      default: ;
    endcase

    res.knob = s2_item_r.knob;
    if (s2_item_r.oor) begin
      res.value  = '0;
      res.moving = 1'b0;
    end else begin
      res.value  = st_nxt.current;
      res.moving = st_nxt.moving;
    end
  end

  assign wr_en   = s2_v_r && !s2_item_r.oor;
  assign wr_addr = AW'(s2_item_r.knob);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_knob_r  <= s2_item_r.knob;
      w_state_r <= st_nxt;
    end
  end

  // result queue, sized for everything the issue credit allows in flight
  assign oq_pop     = out_tvalid & out_tready;
  assign out_tvalid = (oq_cnt_r != 3'd0);
  assign out_tdata  = {4'd0, oq_r[oq_rd_r]};

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (s2_v_r && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 3'd1;
    end else if (!s2_v_r && oq_pop) begin
      oq_cnt_nxt = oq_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 2'd0;
      oq_rd_r  <= 2'd0;
      oq_cnt_r <= 3'd0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (s2_v_r) begin
        oq_wr_r <= oq_wr_r + 2'd1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pot_smoothing_motion_detector.sv =====
// Path: an accepted transfer passes the front queue and the S1 and S2 registers into the result queue.
// Throughput: one item per cycle unless a full result queue holds issue back; the queue, state read, rescale
// and motion stages are registered, and same-knob state is forwarded between back-to-back items.
// Reset: thresholds return to 64 and 32; per-knob valid bits clear at once so every knob
// reads as zero and idle, with no clearing pass.
`default_nettype none
module pot_smoothing_motion_detector #(
  parameter int NUM_KNOBS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [0:0]  in_tuser,   // [0] command
  input  wire logic [15:0] in_tdata,   // [4:0] knob_index, [14:5] adc_sample, [15] force_motion
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [4:0] knob_out, [18:5] filtered_value, [19] moving
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  psmd_pkg::thr_t  thr;
  psmd_pkg::item_t item;
  logic            item_valid;
  logic            item_pop;

  psmd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  psmd_front #(.NUM_KNOBS(NUM_KNOBS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  psmd_back #(.NUM_KNOBS(NUM_KNOBS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .thr        (thr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== test/psmd_reading_check.sv =====
`timescale 1ns / 100ps
// Reading checker: tracks thresholds and per-knob state, predicts each reading and compares.
module psmd_reading_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [0:0]  in_tuser,   // [0] command
  input  wire logic [15:0] in_tdata,   // [4:0] knob_index, [14:5] adc_sample, [15] force_motion
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // [4:0] knob_out, [18:5] filtered_value, [19] moving
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               errors,
  output int               pending
);

  localparam int KNOBS     = 32;
  localparam int IN_LO     = 44;
  localparam int IN_SPAN   = 16294;
  localparam int OUT_HI    = 16383;
  localparam int QUIET_MAX = 3;

  typedef struct {
    logic [4:0]  knob;
    logic [13:0] value;
    logic        moving;
  } reading_t;

  logic [13:0] start_level;
  logic [13:0] stop_level;
  logic [13:0] committed [KNOBS];
  logic [13:0] current   [KNOBS];
  logic        moving    [KNOBS];
  logic [2:0]  quiet     [KNOBS];
  reading_t    expected_readings [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // EMA seeded from half the committed value, doubled, then stretched 44..16338 -> 0..16383
  function automatic logic [13:0] smooth_rescale(logic [9:0] s, logic [13:0] anchor);
    logic [15:0] half;
    logic [15:0] avg;
    int          scaled;
    half = 16'(anchor >> 1);
    avg  = half + 16'(s) - (half >> 3);
    avg  = avg << 1;
    if (avg <= IN_LO) return 14'd0;
    scaled = (int'(avg) - IN_LO) * OUT_HI / IN_SPAN;
    if (scaled > OUT_HI) scaled = OUT_HI;
    return 14'(scaled);
  endfunction

  always @(posedge clk) begin : watch
    reading_t    want;
    reading_t    got;
    logic [4:0]  k;
    logic [13:0] v;
    logic [13:0] diff;
    if (!rst_n) begin
      start_level = 14'd64;
      stop_level  = 14'd32;
      for (int i = 0; i < KNOBS; i++) begin
        committed[i] = '0;
        current[i]   = '0;
        moving[i]    = 1'b0;
        quiet[i]     = '0;
      end
      expected_readings.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == psmd_pkg::REG_START) start_level = cfg_pwdata[13:0];
        else                                     stop_level  = cfg_pwdata[13:0];
      end

      if (out_tvalid && out_tready) begin
        got.knob   = out_tdata[4:0];
        got.value  = out_tdata[18:5];
        got.moving = out_tdata[19];
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual knob %0d value %0d moving %0b",
                   $time, got.knob, got.value, got.moving);
        end else begin
          want = expected_readings.pop_front();
          if (got.knob !== want.knob) begin
            errors++;
            $display("%0t: knob_out expected %0d actual %0d", $time, want.knob, got.knob);
          end
          if (got.value !== want.value) begin
            errors++;
            $display("%0t: knob %0d filtered_value expected %0d actual %0d",
                     $time, want.knob, want.value, got.value);
          end
          if (got.moving !== want.moving) begin
            errors++;
            $display("%0t: knob %0d moving expected %0b actual %0b",
                     $time, want.knob, want.moving, got.moving);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        k = in_tdata[4:0];
        if (psmd_pkg::cmd_t'(in_tuser[0]) == psmd_pkg::CMD_COMMIT) begin
          committed[k] = current[k];
        end else begin
          v          = smooth_rescale(in_tdata[14:5], committed[k]);
          diff       = (v >= committed[k]) ? v - committed[k] : committed[k] - v;
          current[k] = v;
          if (!moving[k]) begin
            if (diff > start_level || in_tdata[15]) moving[k] = 1'b1;
          end else if (diff < stop_level) begin
            quiet[k] = quiet[k] + 3'd1;
            if (quiet[k] > QUIET_MAX) begin
              moving[k] = 1'b0;
              quiet[k]  = '0;
            end
          end else begin
            quiet[k] = '0;
          end
        end
        want.knob   = k;
        want.value  = current[k];
        want.moving = moving[k];
        expected_readings.push_back(want);
      end
    end
    pending = expected_readings.size();
  end

endmodule

// ===== test/pot_smoothing_motion_detector_tb.sv =====
`timescale 1ns / 100ps
// Top of the knob conditioning testbench: clock, reset, stimulus and verdict.
module pot_smoothing_motion_detector_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [0:0]  in_tuser;   // [0] command
  logic [15:0] in_tdata;   // [4:0] knob_index, [14:5] adc_sample, [15] force_motion
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // [4:0] knob_out, [18:5] filtered_value, [19] moving
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          errors;
  int          pending;

  pot_smoothing_motion_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  psmd_reading_check reading_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // result-side backpressure: long ready stretches, short stalls, the odd long one
  always @(posedge clk) begin : sink
    int hold;
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_tready <= 1'b1;
        hold = $urandom_range(0, 30);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        hold = $urandom_range(9, 39);
      end
    end
  end

  task automatic send(psmd_pkg::cmd_t c, logic [4:0] k, logic [9:0] s, logic f, bit steady);
    int r;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {f, s, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!steady) begin
      r   = $urandom_range(0, 99);
      gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic cfg_write(logic idx, logic [13:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // drain: no transfer in flight, every reading back, pipeline quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [9:0] jitter(int base);
    int s;
    s = base + int'($urandom_range(0, 4)) - 2;
    if (s < 0) s = 0;
    if (s > 1023) s = 1023;
    return 10'(s);
  endfunction

  task automatic run_phase(int budget);
    int         n;
    int         r;
    int         base;
    logic [4:0] k;
    bit         steady;
    n = 0;
    while (n < budget) begin
      r      = $urandom_range(0, 99);
      steady = ($urandom_range(0, 3) == 0);
      k      = $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      base   = $urandom_range(0, 1023);
      if (r < 40) begin
        send(psmd_pkg::CMD_SAMPLE, k, 10'($urandom_range(0, 1023)),
             $urandom_range(0, 3) == 0, steady);
        n++;
      end else if (r < 55) begin
        send(psmd_pkg::CMD_COMMIT, k, 10'($urandom_range(0, 1023)),
             1'($urandom_range(0, 1)), steady);
        n++;
      end else if (r < 80) begin
        // settle on one level so the quiet count can run out
        if ($urandom_range(0, 1)) begin
          send(psmd_pkg::CMD_COMMIT, k, 10'($urandom_range(0, 1023)),
               1'($urandom_range(0, 1)), steady);
          n++;
        end
        repeat ($urandom_range(3, 7)) begin
          send(psmd_pkg::CMD_SAMPLE, k, jitter(base), $urandom_range(0, 7) == 0, steady);
          n++;
        end
      end else if (r < 95) begin
        repeat ($urandom_range(2, 6)) begin
          send(psmd_pkg::CMD_SAMPLE, k, jitter(base), $urandom_range(0, 7) == 0, steady);
          send(psmd_pkg::CMD_COMMIT, k, 10'($urandom_range(0, 1023)),
               1'($urandom_range(0, 1)), steady);
          n += 2;
        end
      end else begin
        // ramp the committed value to full scale or back to zero
        base = $urandom_range(0, 1);
        repeat ($urandom_range(24, 36)) begin
          send(psmd_pkg::CMD_SAMPLE, k,
               base ? 10'($urandom_range(1000, 1023)) : 10'($urandom_range(0, 20)),
               $urandom_range(0, 7) == 0, steady);
          send(psmd_pkg::CMD_COMMIT, k, 10'($urandom_range(0, 1023)),
               1'($urandom_range(0, 1)), steady);
          n += 2;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [13:0] start_thr;
    logic [13:0] stop_thr;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = '0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, thresholds at reset values
    send(psmd_pkg::CMD_SAMPLE, 5'd0, 10'd0, 1'b0, 1'b0);
    send(psmd_pkg::CMD_SAMPLE, 5'd31, 10'd1023, 1'b0, 1'b0);
    send(psmd_pkg::CMD_SAMPLE, 5'd1, 10'd22, 1'b0, 1'b0);    // lands exactly on the low end
    send(psmd_pkg::CMD_SAMPLE, 5'd1, 10'd23, 1'b1, 1'b0);    // small step, forced into motion
    send(psmd_pkg::CMD_COMMIT, 5'd2, 10'd1023, 1'b1, 1'b0);
    send(psmd_pkg::CMD_COMMIT, 5'd31, 10'd0, 1'b0, 1'b0);
    repeat (4) send(psmd_pkg::CMD_SAMPLE, 5'd31, 10'd141, 1'b0, 1'b0);  // four quiet samples
    send(psmd_pkg::CMD_SAMPLE, 5'd31, 10'd141, 1'b1, 1'b0);
    send(psmd_pkg::CMD_SAMPLE, 5'd31, 10'd1023, 1'b1, 1'b0);
    repeat (6) begin
      send(psmd_pkg::CMD_SAMPLE, 5'd3, 10'd1023, 1'b0, 1'b0);
      send(psmd_pkg::CMD_COMMIT, 5'd3, 10'd0, 1'b0, 1'b0);
    end
    send(psmd_pkg::CMD_SAMPLE, 5'd3, 10'd0, 1'b0, 1'b0);
    settle();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin start_thr = 14'd64;    stop_thr = 14'd32;    end
        1: begin start_thr = 14'd0;     stop_thr = 14'd0;     end
        2: begin start_thr = 14'd16383; stop_thr = 14'd16383; end
        3: begin start_thr = 14'd0;     stop_thr = 14'd16383; end
        4: begin start_thr = 14'd16383; stop_thr = 14'd0;     end
        5: begin
          start_thr = 14'($urandom_range(0, 300));
          stop_thr  = 14'($urandom_range(0, 300));
        end
        default: begin
          start_thr = 14'($urandom_range(0, 16383));
          stop_thr  = 14'($urandom_range(0, 16383));
        end
      endcase
      cfg_write(psmd_pkg::REG_START, start_thr);
      cfg_write(psmd_pkg::REG_STOP, stop_thr);
      run_phase(170);
      settle();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psmd_pkg.sv
rtl/psmd_cfg.sv
rtl/psmd_front.sv
rtl/psmd_back.sv
rtl/pot_smoothing_motion_detector.sv
test/psmd_reading_check.sv
test/pot_smoothing_motion_detector_tb.sv
